// ----- hdl/pfs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package pfs_pkg;

	localparam int MAX_CHANNELS = 8;
	localparam int QUEUE_DEPTH = 2;
	localparam logic [3:0] MAX_LEN = 4'd8;

	localparam logic OP_STORE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [1:0] CMD_STORE = 2'd0;
	localparam logic [1:0] CMD_STORE_SEND = 2'd1;
	localparam logic [1:0] CMD_TICK = 2'd2;

	localparam logic KIND_FRAME = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic [1:0] code;
		logic [31:0] now;
		logic [2:0] channel;
		logic [28:0] id;
		logic [3:0] len;
		logic [63:0] payload;
		logic [47:0] time_ms;
	} cmd_t;

	function automatic logic [3:0] active_count(input logic [3:0] count, input int num);
		logic [3:0] limit;
		limit = 4'(num);
		return (count > limit) ? limit : count;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/pfs_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module pfs_front
	import pfs_pkg::*;
#(
	parameter int NUM_CHANNELS = MAX_CHANNELS
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic valid,
	output logic ready,
	input wire logic op,
	input wire logic [31:0] now_tick,
	input wire logic [2:0] channel,
	input wire logic [28:0] frame_id,
	input wire logic [3:0] frame_len,
	input wire logic [63:0] frame_payload,
	input wire logic [47:0] frame_time_ms,
	input wire logic [3:0] chan_total,
	input wire logic periodic_mode,
	output logic cmd_valid,
	input wire logic cmd_ready,
	output cmd_t cmd
);

	logic cmd_vld_q;
	cmd_t cmd_q;
	cmd_t next_cmd;
	logic [3:0] n;
	logic keep;

	assign n = active_count(chan_total, NUM_CHANNELS);
	assign ready = !cmd_vld_q || cmd_ready;

	// Stores to channels outside the active range are dropped here.
	assign keep = (op == OP_TICK) || ({1'b0, channel} < n);

	always_comb begin
		next_cmd.code = (op == OP_TICK) ? CMD_TICK :
			(periodic_mode ? CMD_STORE : CMD_STORE_SEND);
		next_cmd.now = now_tick;
		next_cmd.channel = channel;
		next_cmd.id = frame_id;
		next_cmd.len = (frame_len > MAX_LEN) ? MAX_LEN : frame_len;
		next_cmd.payload = frame_payload;
		next_cmd.time_ms = frame_time_ms;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_vld_q <= 1'b0;
		end else if (ready) begin
			cmd_vld_q <= valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (valid && ready) begin
			cmd_q <= next_cmd;
		end
	end

	assign cmd_valid = cmd_vld_q;
	assign cmd = cmd_q;

endmodule
`default_nettype wire

// ----- hdl/pfs_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module pfs_queue
	import pfs_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push_valid,
	output logic push_ready,
	input wire cmd_t push_data,
	output logic pop_valid,
	input wire logic pop_ready,
	output cmd_t pop_data
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [PTR_W:0] FULL_COUNT = (PTR_W + 1)'(QUEUE_DEPTH);

	cmd_t mem [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0] count_q;
	logic do_push;
	logic do_pop;

	assign push_ready = (count_q != FULL_COUNT);
	assign pop_valid = (count_q != '0);
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;
	assign pop_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ----- hdl/pfs_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module pfs_back
	import pfs_pkg::*;
#(
	parameter int NUM_CHANNELS = MAX_CHANNELS
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cmd_valid,
	output logic cmd_ready,
	input wire cmd_t cmd,
	input wire logic [3:0] chan_total,
	input wire logic [63:0] periods_low,
	input wire logic [63:0] periods_high,
	output logic result_valid,
	input wire logic result_ready,
	output logic kind,
	output logic [2:0] out_channel,
	output logic [28:0] out_id,
	output logic [3:0] out_len,
	output logic [63:0] out_payload,
	output logic [47:0] out_time_ms,
	output logic [31:0] wait_ticks,
	output logic last
);

	localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic state_q;

	logic [28:0] slot_id_q [NUM_CHANNELS];
	logic [3:0] slot_len_q [NUM_CHANNELS];
	logic [63:0] slot_payload_q [NUM_CHANNELS];
	logic [47:0] slot_time_q [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] slot_live_q;
	logic [31:0] deadline_q [NUM_CHANNELS];

	logic [31:0] now_q;
	logic [3:0] idx_q;
	logic [31:0] best_q;
	logic have_q;

	logic vld_s1;
	logic [IDX_W-1:0] idx_s1;
	logic due_s1;
	logic [31:0] d1_s1;
	logic [31:0] alt_s1;
	logic [31:0] dold_s1;
	logic vld_s2;
	logic [31:0] newd_s2;

	logic out_valid_q;
	logic out_kind_q;
	logic [2:0] out_channel_q;
	logic [28:0] out_id_q;
	logic [3:0] out_len_q;
	logic [63:0] out_payload_q;
	logic [47:0] out_time_q;
	logic [31:0] out_delay_q;
	logic out_last_q;

	logic [3:0] n;
	logic out_free;
	logic cmd_pop;
	logic pop_tick;
	logic pop_store;
	logic pop_send;
	logic scan_on;
	logic [IDX_W-1:0] sidx;
	logic [IDX_W-1:0] cidx;
	logic [31:0] dl0;
	logic due0;
	logic emit0;
	logic adv0;
	logic [127:0] periods_all;
	logic [15:0] p_raw;
	logic [31:0] p0;
	logic [31:0] diff1;
	logic [31:0] newd1;
	logic [31:0] delta2;
	logic sum_go;

	assign n = active_count(chan_total, NUM_CHANNELS);
	assign out_free = !out_valid_q || result_ready;

	assign cmd_pop = (state_q == ST_IDLE) && cmd_valid &&
		((cmd.code != CMD_STORE_SEND) || out_free);
	assign cmd_ready = cmd_pop;
	assign pop_tick = cmd_pop && (cmd.code == CMD_TICK);
	assign pop_store = cmd_pop && (cmd.code != CMD_TICK);
	assign pop_send = cmd_pop && (cmd.code == CMD_STORE_SEND);
	assign cidx = cmd.channel[IDX_W-1:0];

	// Scan entry: due test, frame send and the two candidate deadlines.
	assign scan_on = (state_q == ST_SCAN) && (idx_q < n);
	assign sidx = idx_q[IDX_W-1:0];
	assign dl0 = deadline_q[sidx];
	assign due0 = (now_q >= dl0);
	assign emit0 = scan_on && due0 && slot_live_q[sidx];
	assign adv0 = scan_on && (!emit0 || out_free);
	assign periods_all = {periods_high, periods_low};
	assign p_raw = periods_all[{idx_q[2:0], 4'b0000} +: 16];
	assign p0 = (p_raw == 16'd0) ? 32'd1 : {16'd0, p_raw};

	// The deadline resyncs when it still lies strictly in the past.
	assign diff1 = now_q - d1_s1;
	assign newd1 = !due_s1 ? dold_s1 :
		(((diff1 != 32'd0) && !diff1[31]) ? alt_s1 : d1_s1);

	assign delta2 = (newd_s2 > now_q) ? (newd_s2 - now_q) : 32'd0;

	assign sum_go = (state_q == ST_SCAN) && (idx_q >= n) && !vld_s1 && !vld_s2 && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			have_q <= 1'b0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			slot_live_q <= '0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				deadline_q[i] <= '0;
			end
		end else begin
			vld_s1 <= adv0;
			vld_s2 <= vld_s1;
			if (pop_tick) begin
				state_q <= ST_SCAN;
				idx_q <= '0;
				have_q <= 1'b0;
			end
			if (pop_store) begin
				slot_live_q[cidx] <= 1'b1;
				deadline_q[cidx] <= cmd.now;
			end
			if (adv0) begin
				idx_q <= idx_q + 4'd1;
			end
			if (vld_s1 && due_s1) begin
				deadline_q[idx_s1] <= newd1;
			end
			if (vld_s2 && (!have_q || (delta2 < best_q))) begin
				have_q <= 1'b1;
			end
			if (sum_go) begin
				state_q <= ST_IDLE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_tick) begin
			now_q <= cmd.now;
			best_q <= '0;
		end
		if (vld_s2 && (!have_q || (delta2 < best_q))) begin
			best_q <= delta2;
		end
		if (pop_store) begin
			slot_id_q[cidx] <= cmd.id;
			slot_len_q[cidx] <= cmd.len;
			slot_payload_q[cidx] <= cmd.payload;
			slot_time_q[cidx] <= cmd.time_ms;
		end
		if (adv0) begin
			idx_s1 <= sidx;
			due_s1 <= due0;
			d1_s1 <= dl0 + p0;
			alt_s1 <= now_q + p0;
			dold_s1 <= dl0;
		end
		if (vld_s1) begin
			newd_s2 <= newd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop_send || (emit0 && out_free) || sum_go) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_send) begin
			out_kind_q <= KIND_FRAME;
			out_channel_q <= cmd.channel;
			out_id_q <= cmd.id;
			out_len_q <= cmd.len;
			out_payload_q <= cmd.payload;
			out_time_q <= cmd.time_ms;
			out_delay_q <= '0;
			out_last_q <= 1'b1;
		end else if (emit0 && out_free) begin
			out_kind_q <= KIND_FRAME;
			out_channel_q <= idx_q[2:0];
			out_id_q <= slot_id_q[sidx];
			out_len_q <= slot_len_q[sidx];
			out_payload_q <= slot_payload_q[sidx];
			out_time_q <= slot_time_q[sidx];
			out_delay_q <= '0;
			out_last_q <= 1'b0;
		end else if (sum_go) begin
			out_kind_q <= KIND_SUMMARY;
			out_channel_q <= '0;
			out_id_q <= '0;
			out_len_q <= '0;
			out_payload_q <= '0;
			out_time_q <= '0;
			out_delay_q <= (best_q == 32'd0) ? 32'd1 : best_q;
			out_last_q <= 1'b1;
		end
	end

	assign result_valid = out_valid_q;
	assign kind = out_kind_q;
	assign out_channel = out_channel_q;
	assign out_id = out_id_q;
	assign out_len = out_len_q;
	assign out_payload = out_payload_q;
	assign out_time_ms = out_time_q;
	assign wait_ticks = out_delay_q;
	assign last = out_last_q;

	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!vld_s1 && !vld_s2))
		else $error("deadline pipeline busy while idle");

	a_stall_holds_index: assert property (@(posedge clk) disable iff (!arst_n)
		(scan_on && !adv0) |=> $stable(idx_q))
		else $error("scan index moved during a result stall");

	a_summary_delay: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_kind_q == KIND_SUMMARY)) |-> (out_delay_q != 32'd0))
		else $error("summary delay is zero");

	a_tick_frame_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_kind_q == KIND_FRAME) && !out_last_q) |-> (state_q == ST_SCAN))
		else $error("tick frame pending after the tick finished");

endmodule
`default_nettype wire

// ----- hdl/periodic_frame_scheduler.sv -----
// Periodic frame scheduler. A request either stores a frame into its channel slot or is a
// scheduler tick. Stores pass through a front register and a two-entry queue into the back
// end; in immediate mode they also return one frame. A tick scans the active channels one
// per cycle, holding while the result side stalls, through the scan entry and the s1
// and s2 deadline stages, sending each due and valid frame in channel order and finishing
// with one summary. Configuration is written through the APB port at byte addresses 0, 8,
// 16 and 24 (active channel count, periodic mode, low period word, high period word); the
// user must write it only while the block is idle; the block does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module periodic_frame_scheduler
	import pfs_pkg::*;
#(
	parameter int NUM_CHANNELS = MAX_CHANNELS
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [4:0] paddr,
	input wire logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready,
	input wire logic valid,
	output logic ready,
	input wire logic op,
	input wire logic [31:0] now_tick,
	input wire logic [2:0] channel,
	input wire logic [28:0] frame_id,
	input wire logic [3:0] frame_len,
	input wire logic [63:0] frame_payload,
	input wire logic [47:0] frame_time_ms,
	output logic result_valid,
	input wire logic result_ready,
	output logic kind,
	output logic [2:0] out_channel,
	output logic [28:0] out_id,
	output logic [3:0] out_len,
	output logic [63:0] out_payload,
	output logic [47:0] out_time_ms,
	output logic [31:0] wait_ticks,
	output logic last
);

	localparam logic [1:0] REG_CHAN_TOTAL = 2'd0;
	localparam logic [1:0] REG_PERIODIC_MODE = 2'd1;
	localparam logic [1:0] REG_PERIODS_LOW = 2'd2;
	localparam logic [1:0] REG_PERIODS_HIGH = 2'd3;

	logic [3:0] chan_total_q;
	logic periodic_mode_q;
	logic [63:0] periods_low_q;
	logic [63:0] periods_high_q;
	logic [1:0] reg_index;
	logic reg_write;

	logic front_valid;
	logic front_ready;
	cmd_t front_cmd;
	logic back_valid;
	logic back_ready;
	cmd_t back_cmd;

	assign pready = 1'b1;
	assign reg_index = paddr[4:3];
	assign reg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_total_q <= '0;
			periodic_mode_q <= 1'b1;
			periods_low_q <= '0;
			periods_high_q <= '0;
		end else if (reg_write) begin
			case (reg_index)
				REG_CHAN_TOTAL: chan_total_q <= pwdata[3:0];
				REG_PERIODIC_MODE: periodic_mode_q <= pwdata[0];
				REG_PERIODS_LOW: periods_low_q <= pwdata;
				REG_PERIODS_HIGH: periods_high_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_index)
			REG_CHAN_TOTAL: prdata = {60'd0, chan_total_q};
			REG_PERIODIC_MODE: prdata = {63'd0, periodic_mode_q};
			REG_PERIODS_LOW: prdata = periods_low_q;
			REG_PERIODS_HIGH: prdata = periods_high_q;
			default: prdata = '0;
		endcase
	end

	pfs_front #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.valid(valid),
		.ready(ready),
		.op(op),
		.now_tick(now_tick),
		.channel(channel),
		.frame_id(frame_id),
		.frame_len(frame_len),
		.frame_payload(frame_payload),
		.frame_time_ms(frame_time_ms),
		.chan_total(chan_total_q),
		.periodic_mode(periodic_mode_q),
		.cmd_valid(front_valid),
		.cmd_ready(front_ready),
		.cmd(front_cmd)
	);

	pfs_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(front_valid),
		.push_ready(front_ready),
		.push_data(front_cmd),
		.pop_valid(back_valid),
		.pop_ready(back_ready),
		.pop_data(back_cmd)
	);

	pfs_back #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(back_valid),
		.cmd_ready(back_ready),
		.cmd(back_cmd),
		.chan_total(chan_total_q),
		.periods_low(periods_low_q),
		.periods_high(periods_high_q),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.kind(kind),
		.out_channel(out_channel),
		.out_id(out_id),
		.out_len(out_len),
		.out_payload(out_payload),
		.out_time_ms(out_time_ms),
		.wait_ticks(wait_ticks),
		.last(last)
	);

endmodule
`default_nettype wire
